@@ design/stt_pkg.sv @@
`timescale 1ns / 1ps

package stt_pkg;

  localparam int SLOTS = 4;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int TOK_W = 64;
  localparam int TIME_W = 32;
  localparam int TTL_W = 31;
  localparam int ENTRY_W = 2 * TOK_W + TIME_W;

  localparam logic [TTL_W-1:0] TTL_RESET = 31'd3600000;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_CHECK  = 2'd1,
    REQ_INVAL  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef struct packed {
    logic [TOK_W-1:0]  token_hi;
    logic [TOK_W-1:0]  token_lo;
    logic [TIME_W-1:0] expiry;
  } entry_t;

endpackage

@@ design/stt_ram.sv @@
`timescale 1ns / 1ps

module stt_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/session_token_table.sv @@
`timescale 1ns / 1ps

// Table of SLOTS 128-bit session tokens, each with a 32-bit wrapping expiry
// time. A request (create, check or invalidate) is one input beat and gives
// exactly one result beat. Each request walks the entry memory through its
// single read port, one entry per cycle, then updates the table in the write
// state and loads the result register in the finish state, which waits
// while the result register holds a beat not yet drained. The result
// register holds a finished beat while the next request is accepted.
// An entry has expired once now_ms - expiry, read as signed, is not negative.
// The lifetime register ttl is written through cfg_we / cfg_data and resets
// to 3600000 ms.

module session_token_table (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [stt_pkg::TTL_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           req_type,
  input  logic [stt_pkg::TOK_W-1:0]            token_hi,
  input  logic [stt_pkg::TOK_W-1:0]            token_lo,
  input  logic                                 token_ok,
  input  logic [stt_pkg::TIME_W-1:0]           now_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 ok,
  output logic [1:0]                           slot_index
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WRITE  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;

  logic [stt_pkg::TTL_W-1:0]  ttl;
  logic [stt_pkg::SLOTS-1:0]  used;

  stt_pkg::req_t               req_kind;
  logic [stt_pkg::TOK_W-1:0]   req_hi;
  logic [stt_pkg::TOK_W-1:0]   req_lo;
  logic                        req_tok_ok;
  logic [stt_pkg::TIME_W-1:0]  req_now;

  logic [stt_pkg::CNT_W-1:0]   rd_idx;
  logic                        ev_valid;
  logic [stt_pkg::SLOT_W-1:0]  ev_idx;
  logic                        found;
  logic [stt_pkg::SLOT_W-1:0]  hit_slot;

  logic                        res_ok;
  logic [stt_pkg::SLOT_W-1:0]  res_slot;
  logic [stt_pkg::SLOT_W-1:0]  out_slot;
  logic [stt_pkg::SLOT_W+1:0]  out_slot_wide;

  logic                        rd_en;
  logic                        ram_we;
  logic [stt_pkg::SLOT_W-1:0]  wr_slot;
  stt_pkg::entry_t             wr_entry;
  logic [stt_pkg::ENTRY_W-1:0] rd_data;
  stt_pkg::entry_t             rd_entry;

  logic [stt_pkg::TIME_W-1:0]  age;
  logic                        ev_used;
  logic                        ev_expired;
  logic                        ev_tok_eq;
  logic                        ev_last;

  assign in_ready = (state == ST_IDLE);

  assign rd_en    = (state == ST_SCAN) && (rd_idx < stt_pkg::CNT_W'(stt_pkg::SLOTS));
  assign rd_entry = stt_pkg::entry_t'(rd_data);

  assign age        = req_now - rd_entry.expiry;
  assign ev_used    = used[ev_idx];
  assign ev_expired = !age[stt_pkg::TIME_W-1];
  assign ev_tok_eq  = (rd_entry.token_hi == req_hi) && (rd_entry.token_lo == req_lo);
  assign ev_last    = ev_valid && (ev_idx == stt_pkg::SLOT_W'(stt_pkg::SLOTS - 1));

  assign ram_we            = (state == ST_WRITE) && (req_kind == stt_pkg::REQ_CREATE);
  assign wr_slot           = found ? hit_slot : '0;
  assign wr_entry.token_hi = req_hi;
  assign wr_entry.token_lo = req_lo;
  assign wr_entry.expiry   = req_now + {1'b0, ttl};

  stt_ram #(
    .DEPTH (stt_pkg::SLOTS),
    .WIDTH (stt_pkg::ENTRY_W),
    .AW    (stt_pkg::SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_slot),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_idx[stt_pkg::SLOT_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl <= stt_pkg::TTL_RESET;
    end else if (cfg_we) begin
      ttl <= cfg_data;
    end
  end

  // payload of the accepted request
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_kind   <= stt_pkg::req_t'(req_type);
      req_hi     <= token_hi;
      req_lo     <= token_lo;
      req_tok_ok <= token_ok;
      req_now    <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      used     <= '0;
      rd_idx   <= '0;
      ev_valid <= 1'b0;
      ev_idx   <= '0;
      found    <= 1'b0;
      hit_slot <= '0;
      res_ok   <= 1'b0;
      res_slot <= '0;
    end else begin
      ev_valid <= rd_en;
      ev_idx   <= rd_idx[stt_pkg::SLOT_W-1:0];
      if (rd_en) begin
        rd_idx <= rd_idx + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            rd_idx   <= '0;
            found    <= 1'b0;
            hit_slot <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (ev_valid) begin
            case (req_kind)
              stt_pkg::REQ_CREATE: begin
                if (ev_used && ev_expired) begin
                  used[ev_idx] <= 1'b0;
                end
                if ((!ev_used || ev_expired) && !found) begin
                  found    <= 1'b1;
                  hit_slot <= ev_idx;
                end
              end
              stt_pkg::REQ_CHECK: begin
                if (req_tok_ok && ev_used && ev_tok_eq && !ev_expired && !found) begin
                  found    <= 1'b1;
                  hit_slot <= ev_idx;
                end
              end
              stt_pkg::REQ_INVAL: begin
                if (req_tok_ok && ev_used && ev_tok_eq && !found) begin
                  found    <= 1'b1;
                  hit_slot <= ev_idx;
                end
              end
              default: begin
              end
            endcase
          end
          if (ev_last) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          case (req_kind)
            stt_pkg::REQ_CREATE: begin
              used[wr_slot] <= 1'b1;
              res_ok        <= 1'b1;
              res_slot      <= wr_slot;
            end
            stt_pkg::REQ_CHECK: begin
              res_ok   <= found;
              res_slot <= hit_slot;
            end
            stt_pkg::REQ_INVAL: begin
              if (found) begin
                used[hit_slot] <= 1'b0;
              end
              res_ok   <= found;
              res_slot <= hit_slot;
            end
            default: begin
              res_ok   <= 1'b0;
              res_slot <= '0;
            end
          endcase
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register: load when free or drained this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && (!out_valid || out_ready)) begin
      ok       <= res_ok;
      out_slot <= res_slot;
    end
  end

  assign out_slot_wide = {2'b00, out_slot};
  assign slot_index    = out_slot_wide[1:0];

`ifndef NO_ASSERTIONS
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SCAN))
    else $error("accepted request did not start the walk");

  a_eval_in_scan: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> (state == ST_SCAN))
    else $error("entry evaluated outside the walk");

  a_write_create: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> used[$past(wr_slot)])
    else $error("created entry not marked in use");

  a_no_read_write: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && rd_en))
    else $error("entry memory read and written in one cycle");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FINISH) && !out_valid) |=> out_valid)
    else $error("finished result not loaded");
`endif

endmodule
